@@ src/wnrd_pkg.sv @@
// Package for the waterfall nibble row decoder: shared types, byte codes and the
// color ramp palette ROM, which is built at elaboration. No dependencies.

`timescale 1ns / 1ps

package wnrd_pkg;

   typedef logic [23:0] color_type;
   typedef logic [255:0][23:0] palette_type;

   typedef enum logic [1:0] {
      KIND_UNDECIDED,
      KIND_ROW,
      KIND_META
   } frame_kind_type;

   // Byte codes of the frame format.
   localparam logic [7:0] ESCAPE_BYTE    = 8'hFF;
   localparam logic [7:0] META_KIND_FREQ = 8'h01;
   localparam logic [7:0] ODD_INDEX_MASK = 8'hF2;
   localparam logic [3:0] EVEN_INDEX_LOW = 4'h2;

   // Byte positions inside a frequency meta frame.
   localparam logic [2:0] FREQ_POS_BYTE0 = 3'd3;
   localparam logic [2:0] FREQ_POS_BYTE1 = 3'd4;
   localparam logic [2:0] FREQ_POS_BYTE2 = 3'd5;
   localparam logic [2:0] FREQ_POS_TOP   = 3'd6;
   localparam logic [2:0] POS_SATURATED  = 3'd7;

   localparam logic [10:0] ROW_WIDTH_RESET = 11'd1024;

   typedef struct packed {
      logic [9:0]  pair_address;
      color_type   color_even;
      logic        even_valid;
      color_type   color_odd;
      logic        odd_valid;
      logic        row_end;
      logic [31:0] freq_reference;
      logic        freq_updated;
   } result_type;

   // Blue ramps up, red follows, green rises as a square root, then white-ish top.
   function automatic palette_type build_palette();
      palette_type pal;
      int          r;
      int          g;
      int          b;
      int          s;
      pal = '0;
      for (int e = 0; e < 256; e++) begin
         r = 0;
         g = 0;
         b = 0;
         s = 0;
         if (e < 64) begin
            b = 2 * e;
         end else if (e < 128) begin
            r = 3 * e - 192;
            b = 2 * e;
         end else if (e < 192) begin
            r = e + 64;
            s = 1024 * (e - 128);
            for (int k = 1; k < 256; k++) begin
               if (k * k <= s) begin
                  g = k;
               end
            end
            b = 511 - 2 * e;
         end else begin
            r = 255;
            g = 255;
            b = 512 + 2 * e;
         end
         pal[e] = {r[7:0], g[7:0], b[7:0]};
      end
      return pal;
   endfunction

   localparam palette_type PALETTE = build_palette();

endpackage

@@ src/wnrd_req_if.sv @@
// Request channel of the waterfall nibble row decoder: one frame byte per request.
// Depends on nothing.

`timescale 1ns / 1ps

interface wnrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_of_frame;

   modport source (output valid, output data_byte, output last_of_frame, input ready);
   modport sink   (input valid, input data_byte, input last_of_frame, output ready);
endinterface

@@ src/wnrd_rsp_if.sv @@
// Response channel of the waterfall nibble row decoder: one pixel pair or status.
// Depends on nothing.

`timescale 1ns / 1ps

interface wnrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  pair_address;
   logic [23:0] color_even;
   logic        even_valid;
   logic [23:0] color_odd;
   logic        odd_valid;
   logic        row_end;
   logic [31:0] freq_reference;
   logic        freq_updated;

   modport source (output valid, output pair_address, output color_even, output even_valid,
                   output color_odd, output odd_valid, output row_end,
                   output freq_reference, output freq_updated, input ready);
   modport sink   (input valid, input pair_address, input color_even, input even_valid,
                   input color_odd, input odd_valid, input row_end,
                   input freq_reference, input freq_updated, output ready);
endinterface

@@ src/wnrd_frame_parser.sv @@
// Frame parser of the waterfall nibble row decoder: frame state, pixel pairing and
// frequency capture. Depends on wnrd_pkg.

`timescale 1ns / 1ps

module wnrd_frame_parser #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 last_of_frame,
   input  logic [10:0]          row_width,
   output logic                 has_result,
   output wnrd_pkg::result_type result
);

   localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

   logic [2:0]                 pos_ff, pos_in;
   wnrd_pkg::frame_kind_type   kind_ff, kind_in;
   logic [7:0]                 meta_ff, meta_in;
   logic [23:0]                part_ff, part_in;
   logic [31:0]                stored_ff, stored_in;
   logic [9:0]                 pair_ff, pair_in;
   logic                       full_ff, full_in;

   logic             pos_zero;
   logic             is_escape;
   logic             take_row;
   logic             lone_escape;
   logic             freq_frame;
   logic             freq_done;
   logic [CMP_W-1:0] width_eff;
   logic [CMP_W-1:0] even_pix;
   logic [CMP_W-1:0] odd_pix;
   logic             even_in_row;
   logic             odd_in_row;
   logic [7:0]       even_index;
   logic [7:0]       odd_index;

   assign pos_zero  = (pos_ff == '0);
   assign is_escape = (data_byte == wnrd_pkg::ESCAPE_BYTE);

   // A leading escape is dropped; a second escape is already pixel data.
   assign take_row = (kind_ff == wnrd_pkg::KIND_ROW)
                  || (kind_ff == wnrd_pkg::KIND_UNDECIDED && pos_zero && !is_escape)
                  || (kind_ff == wnrd_pkg::KIND_UNDECIDED && !pos_zero && is_escape);
   assign lone_escape = (kind_ff == wnrd_pkg::KIND_UNDECIDED) && pos_zero && is_escape
                     && last_of_frame;
   assign freq_frame  = (kind_ff == wnrd_pkg::KIND_META) && (meta_ff == wnrd_pkg::META_KIND_FREQ);
   assign freq_done   = freq_frame && last_of_frame && (pos_ff >= wnrd_pkg::FREQ_POS_TOP);

   assign width_eff = (CMP_W'(row_width) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH)
                                                                : CMP_W'(row_width);
   assign even_pix    = CMP_W'({pair_ff, 1'b0});
   assign odd_pix     = CMP_W'({pair_ff, 1'b1});
   assign even_in_row = !full_ff && (even_pix < width_eff);
   assign odd_in_row  = !full_ff && (odd_pix < width_eff);

   assign even_index = {data_byte[3:0], wnrd_pkg::EVEN_INDEX_LOW};
   assign odd_index  = data_byte & wnrd_pkg::ODD_INDEX_MASK;

   // Next frame state.
   always_comb begin
      pos_in    = (pos_ff != wnrd_pkg::POS_SATURATED) ? pos_ff + 3'd1 : pos_ff;
      kind_in   = kind_ff;
      meta_in   = meta_ff;
      part_in   = part_ff;
      stored_in = stored_ff;
      pair_in   = pair_ff;
      full_in   = full_ff;
      case (kind_ff)
         wnrd_pkg::KIND_UNDECIDED: begin
            if (take_row) begin
               kind_in = wnrd_pkg::KIND_ROW;
            end else if (!pos_zero) begin
               kind_in = wnrd_pkg::KIND_META;
               meta_in = data_byte;
            end
         end
         wnrd_pkg::KIND_META: begin
            if (freq_frame) begin
               case (pos_ff)
                  wnrd_pkg::FREQ_POS_BYTE0: part_in[7:0]   = part_ff[7:0] | data_byte;
                  wnrd_pkg::FREQ_POS_BYTE1: part_in[15:8]  = part_ff[15:8] | data_byte;
                  wnrd_pkg::FREQ_POS_BYTE2: part_in[23:16] = part_ff[23:16] | data_byte;
                  wnrd_pkg::FREQ_POS_TOP:   stored_in      = {data_byte, part_ff};
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      if (take_row && !full_ff) begin
         if (odd_in_row) begin
            pair_in = pair_ff + 10'd1;
         end else begin
            full_in = 1'b1;
         end
      end
      if (last_of_frame) begin
         pos_in  = '0;
         kind_in = wnrd_pkg::KIND_UNDECIDED;
         meta_in = '0;
         part_in = '0;
         pair_in = '0;
         full_in = 1'b0;
      end
   end

   // Result of this byte.
   always_comb begin
      has_result            = 1'b0;
      result                = '0;
      result.freq_reference = stored_in;
      if (take_row) begin
         if (even_in_row) begin
            has_result          = 1'b1;
            result.pair_address = {pair_ff[8:0], 1'b0};
            result.even_valid   = 1'b1;
            result.color_even   = wnrd_pkg::PALETTE[even_index];
            if (odd_in_row) begin
               result.odd_valid = 1'b1;
               result.color_odd = wnrd_pkg::PALETTE[odd_index];
            end
         end
         if (last_of_frame) begin
            has_result     = 1'b1;
            result.row_end = 1'b1;
         end
      end else if (lone_escape) begin
         has_result     = 1'b1;
         result.row_end = 1'b1;
      end else if (freq_done) begin
         has_result          = 1'b1;
         result.freq_updated = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         kind_ff   <= wnrd_pkg::KIND_UNDECIDED;
         meta_ff   <= '0;
         part_ff   <= '0;
         stored_ff <= '0;
         pair_ff   <= '0;
         full_ff   <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         kind_ff   <= kind_in;
         meta_ff   <= meta_in;
         part_ff   <= part_in;
         stored_ff <= stored_in;
         pair_ff   <= pair_in;
         full_ff   <= full_in;
      end
   end

endmodule

@@ src/waterfall_nibble_row_decoder.sv @@
// Top level of the waterfall nibble row decoder: CSR, frame parser and output buffer.
// Depends on wnrd_pkg, wnrd_req_if, wnrd_rsp_if and wnrd_frame_parser.

`timescale 1ns / 1ps

// The decoder takes waterfall frame bytes, one per request, each marked when it
// ends its frame, and turns row frames into pixel pairs and frequency meta frames
// into an updated frequency reference. A frame that opens with 0xFF followed by a
// byte other than 0xFF is a meta frame; kind 1 carries a little-endian 32-bit
// frequency in bytes 3 to 6 and yields one response on its last byte if it had at
// least seven bytes, other meta frames yield nothing. Every other frame is a row:
// a leading 0xFF is dropped, and each byte then gives an even and an odd pixel
// whose colors come from a 256-entry ramp palette ROM. Pixels beyond row_width
// (capped at MAX_WIDTH) are dropped, and filling the rest of the row with black is
// left to the sink. A row byte that places no pixel gives no response unless it
// ends the frame, in which case a row_end response with no valid pixels is sent.
// The block accepts one byte in every clock cycle unless the sink stalls with both
// buffer entries full. The parser does all the work of a byte in the cycle in which
// it is accepted; its response passes through the middle, then the output entry of a
// two-entry buffer; the block keeps taking requests while one response waits to be
// taken. The row_width register may be written only while no request is in flight.

module waterfall_nibble_row_decoder #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic           clock,
   input  logic           reset,
   wnrd_req_if.sink       req_bus,
   wnrd_rsp_if.source     rsp_bus,
   input  logic           csr_wr_en,
   input  logic [10:0]    csr_wr_data
);

   logic [10:0]          row_width_ff;
   logic                 accept;
   logic                 has_result;
   wnrd_pkg::result_type result;

   // Two buffer entries: the middle one catches a fresh response, the output one
   // presents the oldest response to the sink.
   logic                 mid_valid_ff, mid_valid_in;
   wnrd_pkg::result_type mid_ff, mid_in;
   logic                 out_valid_ff, out_valid_in;
   wnrd_pkg::result_type out_ff, out_in;
   logic                 out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= wnrd_pkg::ROW_WIDTH_RESET;
      end else if (csr_wr_en) begin
         row_width_ff <= csr_wr_data;
      end
   end

   // The output entry can load when it is empty or is being taken now; a request
   // is taken whenever the middle entry is empty or can move on.
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !mid_valid_ff || out_free;
   assign accept        = req_bus.valid && req_bus.ready;

   wnrd_frame_parser #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_bus.data_byte),
      .last_of_frame (req_bus.last_of_frame),
      .row_width     (row_width_ff),
      .has_result    (has_result),
      .result        (result)
   );

   always_comb begin
      mid_valid_in = (mid_valid_ff && !out_free) || (accept && has_result);
      mid_in       = (accept && has_result) ? result : mid_ff;
      out_valid_in = out_free ? mid_valid_ff : out_valid_ff;
      out_in       = (out_free && mid_valid_ff) ? mid_ff : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
      out_ff <= out_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.pair_address   = out_ff.pair_address;
   assign rsp_bus.color_even     = out_ff.color_even;
   assign rsp_bus.even_valid     = out_ff.even_valid;
   assign rsp_bus.color_odd      = out_ff.color_odd;
   assign rsp_bus.odd_valid      = out_ff.odd_valid;
   assign rsp_bus.row_end        = out_ff.row_end;
   assign rsp_bus.freq_reference = out_ff.freq_reference;
   assign rsp_bus.freq_updated   = out_ff.freq_updated;

endmodule

@@ src/wnrd_checker.sv @@
// Port-level checks for the waterfall nibble row decoder, with the bind that
// attaches them to the top level. Depends on waterfall_nibble_row_decoder.

`timescale 1ns / 1ps

module wnrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [9:0]  pair_address,
   input logic [23:0] color_even,
   input logic        even_valid,
   input logic [23:0] color_odd,
   input logic        odd_valid,
   input logic        row_end,
   input logic [31:0] freq_reference,
   input logic        freq_updated
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({pair_address, color_even, even_valid, color_odd, odd_valid,
                     row_end, freq_reference, freq_updated}))
      else $error("response changed while stalled");

   // Pixels fill a row from the left, so an odd pixel never stands alone.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && odd_valid |-> even_valid)
      else $error("odd pixel valid without even pixel");

   // A frequency update carries no pixels and does not end a row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && freq_updated |-> !even_valid && !odd_valid && !row_end)
      else $error("frequency update mixed with row data");

   // Pixels outside the row read as zero, and so does the address of an empty pair.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (even_valid || (color_even == '0 && pair_address == '0))
                 && (odd_valid || color_odd == '0))
      else $error("invalid pixel carries a color or address");

endmodule

bind waterfall_nibble_row_decoder wnrd_checker u_wnrd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .pair_address   (rsp_bus.pair_address),
   .color_even     (rsp_bus.color_even),
   .even_valid     (rsp_bus.even_valid),
   .color_odd      (rsp_bus.color_odd),
   .odd_valid      (rsp_bus.odd_valid),
   .row_end        (rsp_bus.row_end),
   .freq_reference (rsp_bus.freq_reference),
   .freq_updated   (rsp_bus.freq_updated)
);
